FILE: design/kcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kcc_pkg;

	// Number of keys scanned in each tick.
	localparam int NUM_KEYS   = 4;
	// Width of the per-key press timer.
	localparam int TIMER_BITS = 8;
	// Width of the key_levels field and of each event field.
	localparam int LEVEL_BITS = 4;
	// Width of each configuration register.
	localparam int CFG_BITS   = 8;
	// Width of the configuration register index.
	localparam int CFG_IDX_BITS = 2;
	// Width at which the timer is compared against the thresholds.
	localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LONG     = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SINGLE   = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [CFG_BITS-1:0] DEBOUNCE_RST = 8'd2;
	localparam logic [CFG_BITS-1:0] WINDOW_RST   = 8'd50;
	localparam logic [CFG_BITS-1:0] LONG_RST     = 8'd100;
	localparam logic [CFG_BITS-1:0] SINGLE_RST   = 8'd30;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_DEBOUNCE = 3'd1,
		PH_HELD     = 3'd2,
		PH_WAIT2    = 3'd3,
		PH_RELEASE  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] debounce_ticks;
		logic [CFG_BITS-1:0] click_window;
		logic [CFG_BITS-1:0] long_ticks;
		logic [CFG_BITS-1:0] single_timeout;
	} cfg_t;

	typedef struct packed {
		logic sgl;
		logic dbl;
		logic lng;
	} key_ev_t;

endpackage

`default_nettype wire

FILE: design/kcc_key.sv
`timescale 1ns / 1ps
`default_nettype none

module kcc_key (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic          pressed,
	input  wire kcc_pkg::cfg_t cfg,
	output kcc_pkg::key_ev_t   ev
);
	import kcc_pkg::*;

	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] timer_q, timer_d;
	logic                  run_q, run_d;
	logic [CMP_BITS-1:0]   t_cmp, deb_cmp, win_cmp, long_cmp, sgl_cmp;
	logic                  below_window, above_long;

	// The timer advances first; the phase logic then sees the new count.
	always_comb begin
		if (!run_q) begin
			timer_d = '0;
		end else if (timer_q == TIMER_MAX) begin
			timer_d = timer_q;
		end else begin
			timer_d = timer_q + 1'b1;
		end
	end

	assign t_cmp    = CMP_BITS'(timer_d);
	assign deb_cmp  = CMP_BITS'(cfg.debounce_ticks);
	assign win_cmp  = CMP_BITS'(cfg.click_window);
	assign long_cmp = CMP_BITS'(cfg.long_ticks);
	assign sgl_cmp  = CMP_BITS'(cfg.single_timeout);

	assign below_window = t_cmp < win_cmp;
	assign above_long   = t_cmp > long_cmp;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (pressed) phase_d = PH_DEBOUNCE;
			end
			PH_DEBOUNCE: begin
				if (pressed && t_cmp > deb_cmp) phase_d = PH_HELD;
			end
			PH_HELD: begin
				// A long press wins when both thresholds are met.
				if (!pressed) begin
					if (above_long) begin
						phase_d = PH_IDLE;
					end else if (below_window) begin
						phase_d = PH_WAIT2;
					end
				end
			end
			PH_WAIT2: begin
				if (pressed && below_window) begin
					phase_d = PH_RELEASE;
				end else if (!pressed && t_cmp >= sgl_cmp) begin
					phase_d = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (!pressed) phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// Events and timer control.
	always_comb begin
		ev    = '0;
		run_d = run_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (pressed) run_d = 1'b1;
			end
			PH_DEBOUNCE: ;
			PH_HELD: begin
				if (!pressed && above_long) begin
					run_d  = 1'b0;
					ev.lng = 1'b1;
				end
			end
			PH_WAIT2: begin
				if (pressed && below_window) begin
					run_d  = 1'b0;
					ev.dbl = 1'b1;
				end else if (!pressed && t_cmp >= sgl_cmp) begin
					run_d  = 1'b0;
					ev.sgl = 1'b1;
				end
			end
			PH_RELEASE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			run_q   <= 1'b0;
			timer_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			run_q   <= run_d;
			timer_q <= timer_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/key_click_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Key click classifier. Every input beat is one scan tick carrying the raw
// active-low levels of four keys (0 pressed, 1 released). Each key runs its own
// debounce and timing state machine and reports a single click, a double click
// or a long press; every tick yields exactly one output beat holding the event
// bits of all keys. The block takes one tick per clock cycle while in_ready is
// high: all key state machines update in the cycle a tick is accepted, and its
// events are registered into the output buffer. This two-entry buffer lets the
// block take a further tick while a finished result is still waiting, so
// in_ready drops only when both entries are held. Thresholds live in four 8-bit
// registers written through the configuration channel (index 0 debounce_ticks,
// 1 click_window, 2 long_ticks, 3 single_timeout), which always accepts; write
// them only while the block is idle. The press timer saturates at its top.
module key_click_classifier (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [kcc_pkg::LEVEL_BITS-1:0]  key_levels,

	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [kcc_pkg::LEVEL_BITS-1:0]       single_events,
	output logic [kcc_pkg::LEVEL_BITS-1:0]       double_events,
	output logic [kcc_pkg::LEVEL_BITS-1:0]       long_events,

	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [kcc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [kcc_pkg::CFG_BITS-1:0]    cfg_data
);
	import kcc_pkg::*;

	// Configuration registers.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RST;
			cfg_q.click_window   <= WINDOW_RST;
			cfg_q.long_ticks     <= LONG_RST;
			cfg_q.single_timeout <= SINGLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data;
				CFG_WINDOW:   cfg_q.click_window   <= cfg_data;
				CFG_LONG:     cfg_q.long_ticks     <= cfg_data;
				CFG_SINGLE:   cfg_q.single_timeout <= cfg_data;
				default: ;
			endcase
		end
	end

	// A tick is taken whenever the skid entry is free.
	logic step;
	assign step = in_valid && in_ready;

	// Per-key state machines. Keys without a level bit read as pressed.
	key_ev_t                   key_ev [NUM_KEYS];
	logic [LEVEL_BITS-1:0]     sgl_now, dbl_now, lng_now;

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		logic pressed;
		if (k < LEVEL_BITS) begin : g_lvl
			assign pressed = !key_levels[k];
		end else begin : g_nolvl
			assign pressed = 1'b1;
		end

		kcc_key u_key (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (step),
			.pressed (pressed),
			.cfg     (cfg_q),
			.ev      (key_ev[k])
		);
	end

	// Gather the event bits that fit the output fields; later keys drop out.
	always_comb begin
		sgl_now = '0;
		dbl_now = '0;
		lng_now = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (k < LEVEL_BITS) begin
				sgl_now[k] = key_ev[k].sgl;
				dbl_now[k] = key_ev[k].dbl;
				lng_now[k] = key_ev[k].lng;
			end
		end
	end

	// Output register with a skid entry behind it.
	logic                  out_valid_q, skid_valid_q;
	logic [LEVEL_BITS-1:0] out_sgl_q, out_dbl_q, out_lng_q;
	logic [LEVEL_BITS-1:0] skid_sgl_q, skid_dbl_q, skid_lng_q;
	logic                  out_free;

	assign in_ready      = !skid_valid_q;
	assign out_valid     = out_valid_q;
	assign single_events = out_sgl_q;
	assign double_events = out_dbl_q;
	assign long_events   = out_lng_q;
	assign out_free      = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				// The skid entry, when held, is older than any new beat.
				out_valid_q  <= skid_valid_q || step;
				skid_valid_q <= 1'b0;
			end else if (step) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_sgl_q <= skid_sgl_q;
				out_dbl_q <= skid_dbl_q;
				out_lng_q <= skid_lng_q;
			end else if (step) begin
				out_sgl_q <= sgl_now;
				out_dbl_q <= dbl_now;
				out_lng_q <= lng_now;
			end
		end else if (step) begin
			skid_sgl_q <= sgl_now;
			skid_dbl_q <= dbl_now;
			skid_lng_q <= lng_now;
		end
	end

endmodule

`default_nettype wire
